// ===== design/s2a_pkg.sv =====
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared types, constants and key tables for the scancode to ASCII unit.
// ----------------------------------------------------------------------------
package s2a_pkg;

  // Character FIFO geometry (ring buffer holds DEPTH-1 characters)
  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [6:0]       char_t;

  // Command codes
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Set 1 scancodes with special meaning
  localparam logic [7:0] CODE_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] CODE_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] CODE_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] CODE_CAPS_MAKE    = 8'h3A;

  // Input transaction
  typedef struct packed {
    logic       cmd;
    logic [7:0] scancode;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    char_t char_out;
    logic  char_valid;
    logic  has_input;
  } out_item_t;

  // Push request from the key map to the FIFO
  typedef struct packed {
    logic  push;
    char_t ch;
  } push_req_t;

  // Next slot of a ring pointer
  function automatic ptr_t next_slot(input ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Unshifted key table
  function automatic char_t rom_lower(input logic [6:0] idx);
    char_t c;
    case (idx)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h2D;
      7'd13: c = 7'h3D;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h71;
      7'd17: c = 7'h77;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6F;
      7'd25: c = 7'h70;
      7'd26: c = 7'h5B;
      7'd27: c = 7'h5D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h61;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;
      7'd39: c = 7'h3B;
      7'd40: c = 7'h27;
      7'd41: c = 7'h60;
      7'd43: c = 7'h5C;
      7'd44: c = 7'h7A;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6E;
      7'd50: c = 7'h6D;
      7'd51: c = 7'h2C;
      7'd52: c = 7'h2E;
      7'd53: c = 7'h2F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Shifted key table
  function automatic char_t rom_upper(input logic [6:0] idx);
    char_t c;
    case (idx)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h21;
      7'd3:  c = 7'h40;
      7'd4:  c = 7'h23;
      7'd5:  c = 7'h24;
      7'd6:  c = 7'h25;
      7'd7:  c = 7'h5E;
      7'd8:  c = 7'h26;
      7'd9:  c = 7'h2A;
      7'd10: c = 7'h28;
      7'd11: c = 7'h29;
      7'd12: c = 7'h5F;
      7'd13: c = 7'h2B;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h51;
      7'd17: c = 7'h57;
      7'd18: c = 7'h45;
      7'd19: c = 7'h52;
      7'd20: c = 7'h54;
      7'd21: c = 7'h59;
      7'd22: c = 7'h55;
      7'd23: c = 7'h49;
      7'd24: c = 7'h4F;
      7'd25: c = 7'h50;
      7'd26: c = 7'h7B;
      7'd27: c = 7'h7D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h41;
      7'd31: c = 7'h53;
      7'd32: c = 7'h44;
      7'd33: c = 7'h46;
      7'd34: c = 7'h47;
      7'd35: c = 7'h48;
      7'd36: c = 7'h4A;
      7'd37: c = 7'h4B;
      7'd38: c = 7'h4C;
      7'd39: c = 7'h3A;
      7'd40: c = 7'h22;
      7'd41: c = 7'h7E;
      7'd43: c = 7'h7C;
      7'd44: c = 7'h5A;
      7'd45: c = 7'h58;
      7'd46: c = 7'h43;
      7'd47: c = 7'h56;
      7'd48: c = 7'h42;
      7'd49: c = 7'h4E;
      7'd50: c = 7'h4D;
      7'd51: c = 7'h3C;
      7'd52: c = 7'h3E;
      7'd53: c = 7'h3F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/s2a_keymap.sv =====
// ----------------------------------------------------------------------------
// s2a_keymap
// Modifier flags and scancode to character translation.
// ----------------------------------------------------------------------------
module s2a_keymap import s2a_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  in_item_t  item_i,
  output push_req_t push_o
);

  logic  shift_q, shift_d;
  logic  caps_q, caps_d;
  char_t ch;

  // Look up the character for the current modifier state
  assign ch = (shift_q ^ caps_q) ? rom_upper(item_i.scancode[6:0])
                                 : rom_lower(item_i.scancode[6:0]);

  // Decode modifiers and character pushes
  always_comb begin
    shift_d     = shift_q;
    caps_d      = caps_q;
    push_o.push = 1'b0;
    push_o.ch   = ch;
    if (item_i.cmd == CMD_SCAN) begin
      unique case (item_i.scancode)
        CODE_LSHIFT_MAKE, CODE_RSHIFT_MAKE:   shift_d = 1'b1;
        CODE_LSHIFT_BREAK, CODE_RSHIFT_BREAK: shift_d = 1'b0;
        CODE_CAPS_MAKE:                       caps_d  = ~caps_q;
        default: begin
          // break codes and prefixes carry bit 7 and are dropped
          push_o.push = ~item_i.scancode[7] && (ch != '0);
        end
      endcase
    end
  end

  // Hold flags between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else if (advance_i) begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

endmodule

// ===== design/s2a_fifo.sv =====
// ----------------------------------------------------------------------------
// s2a_fifo
// Character ring FIFO with a prefetched head entry.
// ----------------------------------------------------------------------------
module s2a_fifo import s2a_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  push_req_t push_i,
  input  logic      pop_req_i,
  output out_item_t result_o
);

  char_t mem_q [DEPTH];
  ptr_t  wr_ptr_q, wr_ptr_d;
  ptr_t  rd_ptr_q, rd_ptr_d;
  char_t head_q;
  logic  empty, full, push, pop;

  // Full and empty status
  assign empty = (wr_ptr_q == rd_ptr_q);
  assign full  = (next_slot(wr_ptr_q) == rd_ptr_q);
  assign push  = advance_i && push_i.push && !full;
  assign pop   = advance_i && pop_req_i && !empty;

  // Advance pointers
  always_comb begin
    wr_ptr_d = push ? next_slot(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop  ? next_slot(rd_ptr_q) : rd_ptr_q;
  end

  // Build the result
  always_comb begin
    result_o.char_out   = pop ? head_q : '0;
    result_o.char_valid = pop;
    result_o.has_input  = (wr_ptr_d != rd_ptr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Write storage and prefetch the next head, bypassing a write to it
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.ch;
    end
    if (push && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= push_i.ch;
    end else begin
      head_q <= mem_q[rd_ptr_d];
    end
  end

endmodule

// ===== design/scancode_to_ascii_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_unit
// PS/2 Set 1 scancode translator with a character FIFO.
// ----------------------------------------------------------------------------
// Each transaction is either a scancode or a read request and yields exactly
// one result. The unit takes one transaction per cycle while the output is
// not stalled. A result passes through the input register, one translation
// and FIFO pass and the result register before it is offered at the output.
// A stalled result holds the input stage, which then stalls the input
// channel. The head of the FIFO is prefetched from storage into a register,
// so a read takes its character from that register. Shift and caps-lock
// codes only update their flags; other break codes and E0/E1 prefixes are
// ignored. The FIFO holds DEPTH-1 characters and drops new ones when full; a
// read from an empty FIFO returns zero with char_valid low.
module scancode_to_ascii_fifo_unit import s2a_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      a_valid_q;
  in_item_t  a_item_q;
  logic      b_valid_q;
  out_item_t b_item_q;
  logic      advance, in_accept;
  push_req_t push_req;
  out_item_t result;

  // Move the input stage forward when the result stage is free
  assign advance    = a_valid_q && (!b_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  s2a_keymap u_keymap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (a_item_q),
    .push_o    (push_req)
  );

  s2a_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .push_i    (push_req),
    .pop_req_i (a_item_q.cmd == CMD_READ),
    .result_o  (result)
  );

  // Input and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        a_valid_q <= 1'b1;
      end else if (advance) begin
        a_valid_q <= 1'b0;
      end
      if (advance) begin
        b_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_item_q <= in_item_i;
    end
    if (advance) begin
      b_item_q <= result;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;

endmodule

// ===== design/s2a_chk.sv =====
// ----------------------------------------------------------------------------
// s2a_chk
// Port-level checks for the scancode to ASCII unit.
// ----------------------------------------------------------------------------
module s2a_chk import s2a_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic [1:0] pending_q;
  logic       last_has_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Track transactions in flight and the last reported FIFO status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      last_has_q <= 1'b0;
    end else begin
      pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        last_has_q <= out_item_o.has_input;
      end
    end
  end

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result without an accepted transaction");

  a_in_flight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two transactions in flight");

  a_popped_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.char_valid |-> out_item_o.char_out != '0)
    else $error("popped character is zero");

  a_idle_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.char_valid |-> out_item_o.char_out == '0)
    else $error("character without a pop");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.char_valid |-> last_has_q)
    else $error("pop reported while previous result showed empty FIFO");

endmodule

bind scancode_to_ascii_fifo_unit s2a_chk u_s2a_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
